@@ design/ddo_pkg.sv @@
// Shared constants, types and helpers for the differential-drive odometry block.
// No dependencies; every other design file imports this package.
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int IT_W         = $clog2(ATAN_LEN);

  localparam logic [15:0] RADIUS_RST = 16'd2130;
  localparam logic [15:0] INVSEP_RST = 16'd5120;

  localparam logic signed [41:0] PI_Q16     = 42'sd205887;
  localparam logic signed [41:0] TWO_PI_Q16 = 42'sd411775;
  localparam logic signed [31:0] INV_TWO_PI = 32'sd683565276;
  localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;
  localparam logic signed [17:0] QUAT_ONE   = 18'sd16384;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_INVSEP = 2'd1;

  typedef logic signed [33:0] cval_t;

  function automatic cval_t atan_q30(input logic [IT_W-1:0] i);
    cval_t r;
    unique case (i)
      5'd0:  r = 34'sh03243F6A8;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Rounds a Q3.30 value to Q1.14 and clamps it to plus or minus one.
  function automatic logic signed [15:0] to_quat(input cval_t v);
    logic signed [34:0] t;
    logic signed [17:0] r;
    t = 35'(v) + 35'sd32768;
    r = 18'(t >>> 16);
    if (r > QUAT_ONE) r = QUAT_ONE;
    else if (r < -QUAT_ONE) r = -QUAT_ONE;
    return r[15:0];
  endfunction

endpackage

@@ design/diff_drive_odometry.sv @@
// Top level of the differential-drive odometry block: sequencer, shared multiplier, pose state.
// Depends on ddo_pkg and ddo_cordic.
//
//  channel | direction | beat contents
//  in_     | input     | left_angle, right_angle
//  out_    | output    | pose_x, pose_y, quat_z, quat_w
//  cfg_    | input     | write enable, register index, 16-bit data
//
// Each item uses the single shared multiplier and runs the CORDIC engine twice, once for the
// heading and once for the half heading. The block takes no new beat until the result is
// registered; a waiting result does not block the next item's work, only its final hand-over.
// Reset is synchronous and clears the pose, heading, last wheel angles and the registers to
// their defaults.
module diff_drive_odometry (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_left_angle,
  input  logic signed [31:0] in_right_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import ddo_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0,  ST_DL  = 4'd1,  ST_DR  = 4'd2,  ST_SUM = 4'd3,
                         ST_DTH  = 4'd4,  ST_HEAD = 4'd5, ST_PH1 = 4'd6,  ST_PH2 = 4'd7,
                         ST_RES  = 4'd8,  ST_ZL  = 4'd9,  ST_CORD = 4'd10, ST_PX = 4'd11,
                         ST_PY   = 4'd12, ST_PY2 = 4'd13, ST_OUT = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [15:0] radius_r, invsep_r;
  logic signed [31:0] x_acc_r, y_acc_r, heading_r, prev_l_r, prev_r_r;
  logic signed [31:0] dl_r, dr_r;
  logic signed [32:0] distl_r, centre_r;
  logic signed [33:0] diff_r;
  logic signed [31:0] phase_r, hphase_r, c_r, s_r;
  logic [1:0] quad_r;
  logic pass_r;
  logic signed [15:0] qz_r, qw_r;
  logic signed [31:0] ox_r, oy_r;
  logic signed [15:0] oqz_r, oqw_r;
  logic out_valid_r;

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] p_r;

  logic signed [31:0] sel_phase;
  logic signed [41:0] h_sum, h_wrap;
  cval_t cx, cy, rot_c, rot_s;
  logic cdone;

  ddo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_ZL),
    .z_in  (p_r[63:30]),
    .x_out (cx),
    .y_out (cy),
    .done  (cdone)
  );

  assign sel_phase = pass_r ? hphase_r : phase_r;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_DL:   begin mul_a = 34'(dl_r);  mul_b = {16'b0, radius_r}; end
      ST_DR:   begin mul_a = 34'(dr_r);  mul_b = {16'b0, radius_r}; end
      ST_DTH:  begin mul_a = diff_r;     mul_b = {16'b0, invsep_r}; end
      ST_PH1:  begin mul_a = 34'(heading_r); mul_b = INV_TWO_PI; end
      ST_RES:  begin mul_a = 34'($signed(sel_phase[29:0])); mul_b = HALF_PI_Q30; end
      ST_PX:   begin mul_a = 34'(centre_r); mul_b = c_r; end
      ST_PY:   begin mul_a = 34'(centre_r); mul_b = s_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    h_sum = 42'(heading_r) + 42'($signed(p_r[50:10]));
    priority if (h_sum > PI_Q16)  h_wrap = h_sum - TWO_PI_Q16;
    else if (h_sum < -PI_Q16)     h_wrap = h_sum + TWO_PI_Q16;
    else                          h_wrap = h_sum;
  end

  // Quadrant correction of the CORDIC result.
  always_comb begin
    unique case (quad_r)
      2'd0:    begin rot_c = cx;  rot_s = cy;  end
      2'd1:    begin rot_c = -cy; rot_s = cx;  end
      2'd2:    begin rot_c = -cx; rot_s = -cy; end
      default: begin rot_c = cy;  rot_s = -cx; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DL;
      ST_DL:   state_nxt = ST_DR;
      ST_DR:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DTH;
      ST_DTH:  state_nxt = ST_HEAD;
      ST_HEAD: state_nxt = ST_PH1;
      ST_PH1:  state_nxt = ST_PH2;
      ST_PH2:  state_nxt = ST_RES;
      ST_RES:  state_nxt = ST_ZL;
      ST_ZL:   state_nxt = ST_CORD;
      ST_CORD: if (cdone) state_nxt = pass_r ? ST_PX : ST_RES;
      ST_PX:   state_nxt = ST_PY;
      ST_PY:   state_nxt = ST_PY2;
      ST_PY2:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      radius_r    <= RADIUS_RST;
      invsep_r    <= INVSEP_RST;
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      heading_r   <= '0;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      pass_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == REG_RADIUS) radius_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_INVSEP) invsep_r <= cfg_wdata;
      // A new result may replace one that leaves in the same cycle.
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          prev_l_r <= in_left_angle;
          prev_r_r <= in_right_angle;
        end
        ST_HEAD: heading_r <= h_wrap[31:0];
        ST_PH2:  pass_r <= 1'b0;
        ST_CORD: if (cdone) pass_r <= 1'b1;
        ST_PY:   x_acc_r <= x_acc_r + p_r[61:30];
        ST_PY2:  y_acc_r <= y_acc_r + p_r[61:30];
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    p_r <= mul_a * 66'(mul_b);
    unique case (state_r)
      ST_IDLE: begin
        dl_r <= in_left_angle - prev_l_r;
        dr_r <= in_right_angle - prev_r_r;
      end
      ST_DR:  distl_r <= p_r[48:16];
      ST_SUM: begin
        centre_r <= 33'((34'(distl_r) + 34'($signed(p_r[48:16]))) >>> 1);
        diff_r   <= 34'($signed(p_r[48:16])) - 34'(distl_r);
      end
      ST_PH2: begin
        phase_r  <= p_r[47:16];
        hphase_r <= p_r[48:17];
      end
      ST_RES: quad_r <= sel_phase[31:30] + {1'b0, sel_phase[29]};
      ST_CORD: if (cdone) begin
        if (!pass_r) begin
          c_r <= rot_c[31:0];
          s_r <= rot_s[31:0];
        end else begin
          qz_r <= to_quat(rot_s);
          qw_r <= to_quat(rot_c);
        end
      end
      ST_OUT: if (!out_valid_r || out_ready) begin
        ox_r  <= x_acc_r;
        oy_r  <= y_acc_r;
        oqz_r <= qz_r;
        oqw_r <= qw_r;
      end
      default: ;
    endcase
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_pose_x = ox_r;
  assign out_pose_y = oy_r;
  assign out_quat_z = oqz_r;
  assign out_quat_w = oqw_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_DL)
    else $error("accepted beat did not start the sequence");
  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the hand-over state");
  a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_quat_z <= 16'sd16384 && out_quat_z >= -16'sd16384 &&
                     out_quat_w <= 16'sd16384 && out_quat_w >= -16'sd16384))
    else $error("quaternion term out of range");
  a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PH1 && $past(h_sum <= PI_Q16 && h_sum >= -PI_Q16))
      |-> heading_r <= 32'sd205887 && heading_r >= -32'sd205887)
    else $error("heading left in range by wrap step is not in range");
endmodule

@@ design/ddo_cordic.sv @@
// Rotation-mode CORDIC engine, one micro-rotation per cycle in Q3.30.
// Depends on ddo_pkg for the arctangent table and step count.
module ddo_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ddo_pkg::cval_t z_in,
  output ddo_pkg::cval_t x_out,
  output ddo_pkg::cval_t y_out,
  output logic          done
);
  import ddo_pkg::*;

  cval_t x_r, y_r, z_r;
  cval_t x_nxt, y_nxt, z_nxt;
  logic [IT_W-1:0] it_r;
  logic run_r, done_r;
  logic last;

  assign last = (it_r == IT_W'(CORDIC_STEPS - 1));

  always_comb begin
    if (!z_r[33]) begin
      x_nxt = x_r - (y_r >>> it_r);
      y_nxt = y_r + (x_r >>> it_r);
      z_nxt = z_r - atan_q30(it_r);
    end else begin
      x_nxt = x_r + (y_r >>> it_r);
      y_nxt = y_r - (x_r >>> it_r);
      z_nxt = z_r + atan_q30(it_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= run_r && last;
      if (start) begin
        run_r <= 1'b1;
        it_r  <= '0;
      end else if (run_r) begin
        it_r <= it_r + 1'b1;
        if (last) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= GAIN_Q30;
      y_r <= '0;
      z_r <= z_in;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign done  = done_r;

  a_it_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> it_r <= IT_W'(CORDIC_STEPS - 1))
    else $error("cordic step counter past last step");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(run_r))
    else $error("cordic done without a run");
endmodule
